FILE: hdl/single_byte_to_utf8_transcoder_core_assert.svh
// Assertion macros shared by the transcoder modules.
// Needs a clock and an active-low reset named at each use.
`ifndef SINGLE_BYTE_TO_UTF8_TRANSCODER_CORE_ASSERT_SVH
`define SINGLE_BYTE_TO_UTF8_TRANSCODER_CORE_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define SBU8_ASSERT_NOW(label, clk_s, rst_s, ante, cons, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
		else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define SBU8_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/sbu8_pkg.sv
// Shared types, codes and the Windows-1252 high-range table.
// No dependencies.
package sbu8_pkg;

	localparam logic [1:0] MODE_UTF8   = 2'd0;
	localparam logic [1:0] MODE_LATIN1 = 2'd1;
	localparam logic [1:0] MODE_CP1252 = 2'd2;

	localparam logic REG_SOURCE_MODE = 1'b0;
	localparam logic REG_LEAD_SKIP   = 1'b1;

	localparam logic [15:0] REPLACEMENT_CP = 16'hFFFD;

	typedef struct packed {
		logic [1:0] source_mode;
		logic [2:0] lead_skip;
	} cfg_t;

	// One encoded run of one to three UTF-8 bytes.
	typedef struct packed {
		logic [1:0] len;
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
	} run_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// Code points for 0x80..0x9F; zero marks an undefined byte.
	function automatic logic [15:0] cp1252_high(input logic [4:0] idx);
		logic [15:0] cp;
		case (idx)
			5'h00: cp = 16'h20AC;
			5'h02: cp = 16'h201A;
			5'h03: cp = 16'h0192;
			5'h04: cp = 16'h201E;
			5'h05: cp = 16'h2026;
			5'h06: cp = 16'h2020;
			5'h07: cp = 16'h2021;
			5'h08: cp = 16'h02C6;
			5'h09: cp = 16'h2030;
			5'h0A: cp = 16'h0160;
			5'h0B: cp = 16'h2039;
			5'h0C: cp = 16'h0152;
			5'h0E: cp = 16'h017D;
			5'h11: cp = 16'h2018;
			5'h12: cp = 16'h2019;
			5'h13: cp = 16'h201C;
			5'h14: cp = 16'h201D;
			5'h15: cp = 16'h2022;
			5'h16: cp = 16'h2013;
			5'h17: cp = 16'h2014;
			5'h18: cp = 16'h02DC;
			5'h19: cp = 16'h2122;
			5'h1A: cp = 16'h0161;
			5'h1B: cp = 16'h203A;
			5'h1C: cp = 16'h0153;
			5'h1E: cp = 16'h017E;
			5'h1F: cp = 16'h0178;
			default: cp = 16'h0000;
		endcase
		return cp;
	endfunction

endpackage

FILE: hdl/sbu8_front.sv
// Front end: accepts source bytes, drops leading stream bytes, encodes to UTF-8 runs.
// Depends on sbu8_pkg.
module sbu8_front import sbu8_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] src_byte,
	input  logic       starts_stream,
	input  q_stat_t    stat,
	output logic       push,
	output run_t       push_run
);

	logic [2:0]  skip_left_q;
	logic [2:0]  skip_eff;
	logic        accept;
	logic [15:0] cp;
	logic [15:0] tab_cp;

	assign in_ready = !stat.full;
	assign accept   = in_valid && in_ready;
	assign skip_eff = starts_stream ? cfg.lead_skip : skip_left_q;
	assign push     = accept && (skip_eff == 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_left_q <= 3'd0;
		end else if (accept) begin
			skip_left_q <= (skip_eff != 3'd0) ? skip_eff - 3'd1 : 3'd0;
		end
	end

	assign tab_cp = cp1252_high(src_byte[4:0]);

	always_comb begin
		cp = {8'h00, src_byte};
		if (cfg.source_mode == MODE_CP1252 && (src_byte inside {[8'h80:8'h9F]})) begin
			cp = (tab_cp == 16'h0000) ? REPLACEMENT_CP : tab_cp;
		end
		push_run = '0;
		if (cfg.source_mode != MODE_LATIN1 && cfg.source_mode != MODE_CP1252) begin
			push_run.len = 2'd1;
			push_run.b0  = src_byte;
		end else if (cp < 16'h0080) begin
			push_run.len = 2'd1;
			push_run.b0  = cp[7:0];
		end else if (cp < 16'h0800) begin
			push_run.len = 2'd2;
			push_run.b0  = 8'hC0 | {3'b000, cp[10:6]};
			push_run.b1  = 8'h80 | {2'b00, cp[5:0]};
		end else begin
			push_run.len = 2'd3;
			push_run.b0  = 8'hE0 | {4'h0, cp[15:12]};
			push_run.b1  = 8'h80 | {2'b00, cp[11:6]};
			push_run.b2  = 8'h80 | {2'b00, cp[5:0]};
		end
	end

endmodule

FILE: hdl/sbu8_queue.sv
// Run queue between the front end and the byte serializer.
// Depends on sbu8_pkg and the assertion macro header.
`include "single_byte_to_utf8_transcoder_core_assert.svh"
module sbu8_queue import sbu8_pkg::*; #(
	parameter int QDEPTH = 4
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  run_t    push_run,
	output q_stat_t stat,
	input  logic    pop,
	output run_t    head
);

	localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CW = $clog2(QDEPTH + 1);

	run_t          mem_q [QDEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign stat.full  = (cnt_q == CW'(QDEPTH));
	assign stat.empty = (cnt_q == '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_run;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`SBU8_ASSERT_NOW(a_no_overflow, clk, arst_n, push, !stat.full || pop, "push into full queue")
	`SBU8_ASSERT_NOW(a_no_underflow, clk, arst_n, pop, !stat.empty, "pop from empty queue")
	`SBU8_ASSERT_NOW(a_head_len, clk, arst_n, !stat.empty, head.len != 2'd0, "queued run has no bytes")

endmodule

FILE: hdl/sbu8_back.sv
// Back end: serializes queued runs into UTF-8 bytes through an output register.
// Depends on sbu8_pkg and the assertion macro header.
`include "single_byte_to_utf8_transcoder_core_assert.svh"
module sbu8_back import sbu8_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  q_stat_t    stat,
	input  run_t       head,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       last_of_run
);

	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       last_q;
	logic       load;
	logic       cur_last;
	logic [7:0] cur_byte;

	assign load     = !stat.empty && (!out_valid_q || out_ready);
	assign cur_last = ((idx_q + 2'd1) == head.len);
	assign pop      = load && cur_last;

	always_comb begin
		case (idx_q)
			2'd0:    cur_byte = head.b0;
			2'd1:    cur_byte = head.b1;
			default: cur_byte = head.b2;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
			idx_q       <= cur_last ? 2'd0 : idx_q + 2'd1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= cur_byte;
			last_q     <= cur_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign last_of_run = last_q;

	`SBU8_ASSERT_NOW(a_mid_run_head, clk, arst_n, idx_q != 2'd0, !stat.empty && idx_q < head.len, "run index past its head")
	`SBU8_ASSERT_NEXT(a_last_rewinds, clk, arst_n, pop, idx_q == 2'd0, "index not cleared after last byte")
	`SBU8_ASSERT_NEXT(a_load_shows, clk, arst_n, load, out_valid && out_byte == $past(cur_byte), "loaded byte not presented")

endmodule

FILE: hdl/single_byte_to_utf8_transcoder_core.sv
// Top level of the single-byte to UTF-8 transcoder: config registers and the three parts.
// Depends on sbu8_pkg, sbu8_front, sbu8_queue and sbu8_back.
//
//  Channel  Handshake            Payload
//  input    in_valid/in_ready    src_byte[7:0], starts_stream
//  output   out_valid/out_ready  out_byte[7:0], last_of_run
//  config   cfg_we               cfg_index (0 source_mode, 1 lead_skip), cfg_data[2:0]
//
// One output byte per cycle while out_ready is high and runs are queued: an
// item gives the back end one, two or three bytes by its UTF-8 encoding length;
// dropped items are taken and make no output. Input is taken every cycle while
// the run queue (QDEPTH entries) has room, so each side stalls on its own.
// Asynchronous reset clears the registers, the skip count and the queue.
module single_byte_to_utf8_transcoder_core import sbu8_pkg::*; #(
	parameter int QDEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [2:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] src_byte,
	input  logic       starts_stream,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       last_of_run
);

	cfg_t    cfg_q;
	q_stat_t stat;
	logic    push;
	run_t    push_run;
	logic    pop;
	run_t    head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SOURCE_MODE: cfg_q.source_mode <= cfg_data[1:0];
				REG_LEAD_SKIP:   cfg_q.lead_skip   <= cfg_data;
				default:         cfg_q             <= cfg_q;
			endcase
		end
	end

	sbu8_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.src_byte      (src_byte),
		.starts_stream (starts_stream),
		.stat          (stat),
		.push          (push),
		.push_run      (push_run)
	);

	sbu8_queue #(.QDEPTH(QDEPTH)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_run (push_run),
		.stat     (stat),
		.pop      (pop),
		.head     (head)
	);

	sbu8_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.stat        (stat),
		.head        (head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.last_of_run (last_of_run)
	);

endmodule
